// ----- rtl/evs_pkg.sv -----
// Shared types and constants of the edge voxel sampler.
// No dependencies; every other RTL file but the checker imports it.
`default_nettype none
package evs_pkg;

   localparam int FRAC_BITS   = 4;
   localparam int MAX_SAMPLES = 64;
   localparam int HALF_COUNT  = MAX_SAMPLES / 2;
   localparam int RECIP_SHIFT = 16;

   localparam int COORD_W = 16;
   localparam int DELTA_W = 17;
   localparam int WHOLE_W = 12;
   localparam int LEN2_W  = 35;
   localparam int SCALE_W = 18;
   localparam int CNT_W   = $clog2(HALF_COUNT + 2);
   localparam int TOT_W   = CNT_W + 1;
   localparam int DIV_W   = 17;
   localparam int DVSR_W  = 8;
   localparam int STEPQ_W = 18;

   localparam logic [DIV_W-1:0] RECIP_NUM = DIV_W'(1) << RECIP_SHIFT;

   typedef enum logic [2:0] {
      F_IDLE,
      F_SQ,
      F_MUL,
      F_CMP,
      F_DIV,
      F_PUSH
   } front_state_type;

   typedef struct packed {
      logic [2:0][COORD_W-1:0] origin;
      logic [2:0][STEPQ_W-1:0] step_q;
      logic [2:0][DVSR_W-1:0]  step_r;
      logic [TOT_W-1:0]        total;
      logic                    sat;
      logic [DIV_W-1:0]        recip;
      logic [DVSR_W-1:0]       vox;
   } job_type;

endpackage
`default_nettype wire

// ----- rtl/edge_voxel_sampler_top.sv -----
// Top level of the edge voxel sampler: front end, job queue, back end.
// Depends on evs_pkg, evs_front, evs_queue, evs_back, evs_div.
//
// Usage:
//  - req_* takes one edge per item: six Q12.4 signed coordinates.
//  - rsp_* returns 2n sample items per edge, each a snapped cube corner
//    in whole units; rsp_tlast marks the final sample, rsp_tuser flags an
//    edge whose count was clipped at 32.
//  - csr_we/csr_wdata write the voxel size (0 acts as 1). Write only
//    while idle.
//  Operation:
//  - The front end sums the squared length, runs the count search (up
//    to 33 steps) and then the delta dividers, and accepts the next
//    edge only when that is done and the job, if any, is queued.
//  - The back end emits one sample per cycle while rsp_tready is high.
//    An edge with n = 0 yields no item.
//  - The two-entry job queue lets the front end work on the next edge
//    while the back end is still emitting.
//  Reset: synchronous, clears all control state, voxel size back to 1.
//  Stall: when rsp_tready is low the whole sample pipeline holds; the
//  queue fills and then req_tready drops.
`default_nettype none
module edge_voxel_sampler_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // start_x, start_y, start_z, end_x, end_y, end_z (16 bits each)
   input  wire logic [95:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // cube_x, cube_y, cube_z (12 bits each), 4 zero bits
   output logic [39:0]      rsp_tdata,
   output logic             rsp_tlast,
   // saturated
   output logic             rsp_tuser,
   input  wire logic        csr_we,
   input  wire logic [7:0]  csr_wdata
);
   import evs_pkg::*;

   logic [DVSR_W-1:0]       vox_ff, vox_in;
   logic [DVSR_W-1:0]       vox_eff;
   logic                    fq_valid, fq_ready;
   logic                    qb_valid, qb_ready;
   job_type                 fq_data, qb_data;
   logic [2:0][WHOLE_W-1:0] cube;

   assign vox_in  = csr_we ? csr_wdata : vox_ff;
   assign vox_eff = (vox_ff == '0) ? DVSR_W'(1) : vox_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vox_ff <= DVSR_W'(1);
      end else begin
         vox_ff <= vox_in;
      end
   end

   evs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .vox        (vox_eff),
      .job_valid  (fq_valid),
      .job_ready  (fq_ready),
      .job_data   (fq_data)
   );

   evs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   evs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (qb_valid),
      .job_ready  (qb_ready),
      .job_data   (qb_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cube       (cube),
      .last       (rsp_tlast),
      .saturated  (rsp_tuser)
   );

   assign rsp_tdata = {4'b0000, cube[2], cube[1], cube[0]};
endmodule
`default_nettype wire

// ----- rtl/evs_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on evs_pkg for widths.
`default_nettype none
module evs_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [evs_pkg::DIV_W-1:0]  dividend,
   input  wire logic [evs_pkg::DVSR_W-1:0] divisor,
   output logic                            busy,
   output logic [evs_pkg::DIV_W-1:0]       quotient,
   output logic [evs_pkg::DVSR_W-1:0]      remainder
);
   import evs_pkg::*;

   localparam int STEP_W = $clog2(DIV_W + 1);

   logic [STEP_W-1:0] step_ff, step_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DVSR_W-1:0] rem_ff, rem_in;
   logic [DVSR_W-1:0] dvsr_ff, dvsr_in;
   logic [DVSR_W:0]   trial;

   always_comb begin
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      if (start) begin
         step_in = STEP_W'(DIV_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvsr_in = divisor;
      end else if (step_ff != '0) begin
         step_in = step_ff - 1'b1;
         if (trial >= {1'b0, dvsr_ff}) begin
            rem_in = DVSR_W'(trial - {1'b0, dvsr_ff});
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVSR_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
   end

   assign busy      = (step_ff != '0);
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

// ----- rtl/evs_front.sv -----
// Front end: takes an edge, finds the sample count, divides the deltas.
// Depends on evs_pkg and evs_div.
`default_nettype none
module evs_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [95:0]                req_tdata,
   input  wire logic [evs_pkg::DVSR_W-1:0] vox,
   output logic                            job_valid,
   input  wire logic                       job_ready,
   output evs_pkg::job_type                job_data
);
   import evs_pkg::*;

   front_state_type state_ff, state_in;
   logic [2:0][COORD_W-1:0] org_ff, org_in;
   logic [2:0][DELTA_W-1:0] dlt_ff, dlt_in;
   logic [LEN2_W-1:0]       len2_ff, len2_in;
   logic [1:0]              idx_ff, idx_in;
   logic [SCALE_W-1:0]      m_ff, m_in;
   logic [CNT_W-1:0]        k_ff, k_in;
   logic [2*SCALE_W-1:0]    sq_ff, sq_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic                    sat_ff, sat_in;
   logic [DVSR_W-1:0]       v_ff, v_in;

   logic signed [DELTA_W-1:0]   d_sel;
   logic signed [2*DELTA_W-1:0] d_sq;
   logic [SCALE_W-1:0]          unit;
   logic                        div_start;
   logic [2:0]                  div_busy;
   logic                        rc_busy;
   logic [2:0][DIV_W-1:0]       qu;
   logic [2:0][DVSR_W-1:0]      ru;
   logic [DIV_W-1:0]            recip;
   logic [DVSR_W-1:0]           rc_rem;
   logic [TOT_W-1:0]            total;
   logic [2:0][DIV_W-1:0]       mag;

   assign unit  = SCALE_W'(v_ff) << FRAC_BITS;
   assign total = {n_ff, 1'b0};
   assign d_sel = dlt_ff[idx_ff];
   assign d_sq  = d_sel * d_sel;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mag[k] = dlt_ff[k][DELTA_W-1] ? DIV_W'(-dlt_ff[k]) : DIV_W'(dlt_ff[k]);
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_axis
      evs_div u_div (
         .clock     (clock),
         .reset     (reset),
         .start     (div_start),
         .dividend  (mag[g]),
         .divisor   (DVSR_W'(total)),
         .busy      (div_busy[g]),
         .quotient  (qu[g]),
         .remainder (ru[g])
      );
   end

   evs_div u_recip (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (RECIP_NUM),
      .divisor   (v_ff),
      .busy      (rc_busy),
      .quotient  (recip),
      .remainder (rc_rem)
   );

   always_comb begin
      state_in   = state_ff;
      org_in     = org_ff;
      dlt_in     = dlt_ff;
      len2_in    = len2_ff;
      idx_in     = idx_ff;
      m_in       = m_ff;
      k_in       = k_ff;
      sq_in      = sq_ff;
      n_in       = n_ff;
      sat_in     = sat_ff;
      v_in       = v_ff;
      req_tready = 1'b0;
      job_valid  = 1'b0;
      div_start  = 1'b0;
      case (state_ff)
         F_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               for (int k = 0; k < 3; k++) begin
                  org_in[k] = req_tdata[16*k +: 16];
                  dlt_in[k] = {req_tdata[16*(k+3)+15], req_tdata[16*(k+3) +: 16]}
                            - {req_tdata[16*k+15], req_tdata[16*k +: 16]};
               end
               len2_in  = '0;
               idx_in   = '0;
               v_in     = vox;
               m_in     = SCALE_W'(vox) << FRAC_BITS;
               k_in     = CNT_W'(1);
               n_in     = '0;
               sat_in   = 1'b0;
               state_in = F_SQ;
            end
         end
         F_SQ: begin
            len2_in = len2_ff + LEN2_W'(unsigned'(d_sq));
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == 2'd2) begin
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            sq_in    = m_ff * m_ff;
            state_in = F_CMP;
         end
         F_CMP: begin
            if (sq_ff <= {1'b0, len2_ff}) begin
               if (k_ff == CNT_W'(HALF_COUNT + 1)) begin
                  sat_in    = 1'b1;
                  div_start = 1'b1;
                  state_in  = F_DIV;
               end else begin
                  n_in     = k_ff;
                  k_in     = k_ff + 1'b1;
                  m_in     = m_ff + unit;
                  state_in = F_MUL;
               end
            end else if (n_ff == '0) begin
               state_in = F_IDLE;   // too short for any sample
            end else begin
               div_start = 1'b1;
               state_in  = F_DIV;
            end
         end
         F_DIV: begin
            if (!rc_busy && div_busy == '0) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            job_valid = 1'b1;
            if (job_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   // floor division from the unsigned quotient and remainder
   always_comb begin
      job_data.origin = org_ff;
      job_data.total  = total;
      job_data.sat    = sat_ff;
      job_data.recip  = recip;
      job_data.vox    = v_ff;
      for (int k = 0; k < 3; k++) begin
         if (!dlt_ff[k][DELTA_W-1]) begin
            job_data.step_q[k] = STEPQ_W'(qu[k]);
            job_data.step_r[k] = ru[k];
         end else if (ru[k] == '0) begin
            job_data.step_q[k] = -STEPQ_W'(qu[k]);
            job_data.step_r[k] = '0;
         end else begin
            job_data.step_q[k] = -STEPQ_W'(qu[k]) - 1'b1;
            job_data.step_r[k] = DVSR_W'(total) - ru[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      org_ff  <= org_in;
      dlt_ff  <= dlt_in;
      len2_ff <= len2_in;
      idx_ff  <= idx_in;
      m_ff    <= m_in;
      k_ff    <= k_in;
      sq_ff   <= sq_in;
      n_ff    <= n_in;
      sat_ff  <= sat_in;
      v_ff    <= v_in;
   end
endmodule
`default_nettype wire

// ----- rtl/evs_queue.sv -----
// Two-entry job queue between front and back end.
// Depends on evs_pkg for the job record.
`default_nettype none
module evs_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire evs_pkg::job_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output evs_pkg::job_type      out_data
);
   import evs_pkg::*;

   job_type    mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/evs_back.sv -----
// Back end: steps through the samples of a job and snaps them to voxels.
// Depends on evs_pkg.
`default_nettype none
module evs_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        job_valid,
   output logic                             job_ready,
   input  wire evs_pkg::job_type            job_data,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [2:0][evs_pkg::WHOLE_W-1:0] cube,
   output logic                             last,
   output logic                             saturated
);
   import evs_pkg::*;

   localparam int POS_W  = STEPQ_W + 1;
   localparam int PROD_W = WHOLE_W + DIV_W;
   localparam int Q0_W   = PROD_W - RECIP_SHIFT;
   localparam int MV_W   = Q0_W + DVSR_W;

   job_type                 job_ff;
   logic                    busy_ff, busy_in;
   logic [TOT_W-1:0]        i_ff, i_in;
   logic [2:0][STEPQ_W-1:0] accq_ff, accq_in;
   logic [2:0][DVSR_W:0]    accr_ff, accr_in;

   logic                    v1_ff, v2_ff, v3_ff;
   logic [2:0][WHOLE_W-1:0] a1_ff, a2_ff, a3_ff;
   logic [2:0]              neg1_ff, neg2_ff, neg3_ff;
   logic                    last1_ff, last2_ff, last3_ff;
   logic                    sat1_ff, sat2_ff, sat3_ff;
   logic [DIV_W-1:0]        recip1_ff;
   logic [DVSR_W-1:0]       vox1_ff, vox2_ff, vox3_ff;
   logic [2:0][PROD_W-1:0]  p2_ff;
   logic [2:0][MV_W-1:0]    mv3_ff;

   logic                    out_v_ff;
   logic [2:0][WHOLE_W-1:0] cube_ff, cube_in;
   logic                    last_ff, sat_ff;

   logic                    en, emit, pop, is_last;
   logic [2:0][POS_W-1:0]   pos;
   logic [2:0][WHOLE_W-1:0] f, a;
   logic [2:0][DVSR_W:0]    r_sum;

   assign en      = !out_v_ff || rsp_tready;
   assign emit    = en && busy_ff;
   assign pop     = en && !busy_ff && job_valid;
   assign is_last = (i_ff + 1'b1 == job_ff.total);
   assign job_ready = pop;

   // incremental floor(i*delta/total): quotient and remainder walk
   always_comb begin
      busy_in = busy_ff;
      i_in    = i_ff;
      accq_in = accq_ff;
      accr_in = accr_ff;
      for (int k = 0; k < 3; k++) begin
         pos[k] = POS_W'(signed'(job_ff.origin[k])) + POS_W'(signed'(accq_ff[k]));
         f[k]   = pos[k][FRAC_BITS +: WHOLE_W];
         a[k]   = f[k][WHOLE_W-1] ? -f[k] : f[k];
         r_sum[k] = accr_ff[k] + {1'b0, job_ff.step_r[k]};
      end
      if (pop) begin
         busy_in = 1'b1;
         i_in    = '0;
         accq_in = '0;
         accr_in = '0;
      end else if (emit) begin
         i_in = i_ff + 1'b1;
         if (is_last) busy_in = 1'b0;
         for (int k = 0; k < 3; k++) begin
            if (r_sum[k] >= (DVSR_W+1)'(job_ff.total)) begin
               accr_in[k] = r_sum[k] - (DVSR_W+1)'(job_ff.total);
               accq_in[k] = accq_ff[k] + job_ff.step_q[k] + 1'b1;
            end else begin
               accr_in[k] = r_sum[k];
               accq_in[k] = accq_ff[k] + job_ff.step_q[k];
            end
         end
      end
   end

   // last stage: remainder correction and sign restore
   always_comb begin
      logic [WHOLE_W-1:0] r0, r1, m;
      for (int k = 0; k < 3; k++) begin
         r0 = a3_ff[k] - mv3_ff[k][WHOLE_W-1:0];
         r1 = (r0 >= WHOLE_W'(vox3_ff)) ? r0 - WHOLE_W'(vox3_ff) : r0;
         m  = a3_ff[k] - r1;
         if (a3_ff[k] > WHOLE_W'(vox3_ff)) begin
            cube_in[k] = neg3_ff[k] ? -m : m;
         end else begin
            cube_in[k] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (en) begin
            v1_ff    <= emit;
            v2_ff    <= v1_ff;
            v3_ff    <= v2_ff;
            out_v_ff <= v3_ff;
         end
      end
      i_ff    <= i_in;
      accq_ff <= accq_in;
      accr_ff <= accr_in;
      if (pop) job_ff <= job_data;
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            a1_ff[k]   <= a[k];
            neg1_ff[k] <= f[k][WHOLE_W-1];
            p2_ff[k]   <= PROD_W'(a1_ff[k]) * PROD_W'(recip1_ff);
            mv3_ff[k]  <= MV_W'(p2_ff[k][RECIP_SHIFT +: Q0_W]) * MV_W'(vox2_ff);
         end
         last1_ff  <= is_last;
         sat1_ff   <= job_ff.sat;
         recip1_ff <= job_ff.recip;
         vox1_ff   <= job_ff.vox;
         a2_ff     <= a1_ff;
         neg2_ff   <= neg1_ff;
         last2_ff  <= last1_ff;
         sat2_ff   <= sat1_ff;
         vox2_ff   <= vox1_ff;
         a3_ff     <= a2_ff;
         neg3_ff   <= neg2_ff;
         last3_ff  <= last2_ff;
         sat3_ff   <= sat2_ff;
         vox3_ff   <= vox2_ff;
         cube_ff   <= cube_in;
         last_ff   <= last3_ff;
         sat_ff    <= sat3_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign cube       = cube_ff;
   assign last       = last_ff;
   assign saturated  = sat_ff;
endmodule
`default_nettype wire

// ----- rtl/edge_voxel_sampler_checker.sv -----
// Port-level checks for the edge voxel sampler, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module edge_voxel_sampler_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic        rsp_tuser
);
   // no result right after reset
   a_rst_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // front end comes up ready
   a_rst_ready: assert property (@(posedge clock) reset |=> req_tready)
      else $error("not ready after reset");

   // an accepted edge keeps the front end busy for the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("ready right after accepting an edge");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser)))
      else $error("stalled result changed");
endmodule

bind edge_voxel_sampler_top edge_voxel_sampler_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
